// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent checks clocked on clk and held off by rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/bcwt_pkg.sv =====
// ----------------------------------------------------------------------------
// Bus command word transceiver package
// Widths, request codes, register indexes and reset values of the transceiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bcwt_pkg;

  // Command word, ADC sample, bit position, period, tally and acknowledge widths
  localparam int WORD_BITS   = 32;
  localparam int SAMPLE_BITS = 10;
  localparam int POS_BITS    = $clog2(WORD_BITS);
  localparam int PERIOD_BITS = 16;
  localparam int TALLY_BITS  = 16;
  localparam int ACK_BITS    = 4;

  // Padded bus widths
  localparam int IN_DATA_BITS  = 48;
  localparam int OUT_DATA_BITS = 72;
  localparam int OUT_USED_BITS = 71;

  // Register reset values
  localparam logic [PERIOD_BITS-1:0] BIT_PERIOD_RST  = 16'd1972;
  localparam logic [SAMPLE_BITS-1:0] HIGH_LEVEL_RST  = 10'd138;
  localparam logic [SAMPLE_BITS-1:0] CARRIER_RST     = 10'd370;
  localparam logic [ACK_BITS-1:0]    ACK_WAIT_RST    = 4'd3;

  // Request kinds carried in tuser
  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_EDGE = 2'd1,
    OP_SEND = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  // Transceiver phase, also reported as the mode field
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RX   = 2'd1,
    PH_TX   = 2'd2
  } phase_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_BIT_PERIOD = 2'd0,
    CFG_HIGH_LEVEL = 2'd1,
    CFG_CARRIER    = 2'd2,
    CFG_ACK_WAIT   = 2'd3
  } cfg_idx_t;

endpackage

// ===== hw/rtl/bus_command_word_transceiver.sv =====
// A result appears on the master side in the cycle after its request is taken.
// One request per cycle while results are read; the single output register frees itself when read.
// Every request gives exactly one result; the timer and shift state step at most once per request.
// Reset (rst, synchronous) idles the transceiver, clears counters, last word and levels,
// and restores the configuration registers to their defaults.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// ----------------------------------------------------------------------------
// Bus command word transceiver
// Receives and sends 32-bit command words on a sampled intercom bus line.
// ----------------------------------------------------------------------------
module bus_command_word_transceiver (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration write port
  input  logic                                 cfg_wen,
  input  logic [1:0]                           cfg_index,
  input  logic [bcwt_pkg::PERIOD_BITS-1:0]     cfg_data,
  // Request stream
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // bus_sample [9:0], send_word [41:10], zero padding [47:42]
  input  logic [bcwt_pkg::IN_DATA_BITS-1:0]    s_tdata,
  // op [1:0]
  input  logic [1:0]                           s_tuser,
  // Result stream
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // line_drive [0], carrier_on [1], mode [3:2], word_ready [4], last_word [36:5],
  // send_ok [37], send_timeout [38], received_total [54:39], sent_total [70:55],
  // zero padding [71]
  output logic [bcwt_pkg::OUT_DATA_BITS-1:0]   m_tdata
);

  import bcwt_pkg::*;

  // Configuration registers
  logic [PERIOD_BITS-1:0] bit_period;
  logic [SAMPLE_BITS-1:0] high_level_code;
  logic [SAMPLE_BITS-1:0] carrier_code;
  logic [ACK_BITS-1:0]    ack_wait_periods;

  // Transceiver state
  phase_t                 phase, phase_next;
  logic [POS_BITS-1:0]    bit_pos, bit_pos_next;
  logic [PERIOD_BITS-1:0] period_left, period_left_next;
  logic [WORD_BITS-1:0]   rx_shift, rx_shift_next;
  logic [WORD_BITS-1:0]   tx_shift, tx_shift_next;
  logic [WORD_BITS-1:0]   held_word, held_word_next;
  logic [TALLY_BITS-1:0]  rx_tally, rx_tally_next;
  logic [TALLY_BITS-1:0]  tx_tally, tx_tally_next;
  logic                   drive_level, drive_level_next;
  logic                   carrier_level, carrier_level_next;
  logic [ACK_BITS-1:0]    ack_count, ack_count_next;

  // Request fields
  op_t                    op;
  logic [SAMPLE_BITS-1:0] bus_sample;
  logic [WORD_BITS-1:0]   send_word;
  logic                   in_take;

  // Per-request events
  logic                   bit_event;
  logic                   sample_high;
  logic [WORD_BITS-1:0]   rx_shift_upd;
  logic [POS_BITS-1:0]    tx_next_pos;
  logic                   word_ready;
  logic                   send_ok;
  logic                   send_timeout;
  logic                   ack_expired;

  assign op         = op_t'(s_tuser);
  assign bus_sample = s_tdata[SAMPLE_BITS-1:0];
  assign send_word  = s_tdata[SAMPLE_BITS +: WORD_BITS];

  // The output register takes a new result whenever it is empty or being read
  assign s_tready = !m_tvalid || m_tready;
  assign in_take  = s_tvalid && s_tready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_period       <= BIT_PERIOD_RST;
      high_level_code  <= HIGH_LEVEL_RST;
      carrier_code     <= CARRIER_RST;
      ack_wait_periods <= ACK_WAIT_RST;
    end else if (cfg_wen) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_BIT_PERIOD: bit_period       <= cfg_data;
        CFG_HIGH_LEVEL: high_level_code  <= cfg_data[SAMPLE_BITS-1:0];
        CFG_CARRIER:    carrier_code     <= cfg_data[SAMPLE_BITS-1:0];
        CFG_ACK_WAIT:   ack_wait_periods <= cfg_data[ACK_BITS-1:0];
        default:        ;
      endcase
    end
  end

  // Bit timing and the received word with the current bit written in
  always_comb begin
    bit_event   = (op == OP_TICK) && (phase != PH_IDLE) && (period_left <= PERIOD_BITS'(1));
    sample_high = bus_sample > high_level_code;
    ack_expired = ack_count >= ack_wait_periods;
    tx_next_pos = bit_pos - POS_BITS'(1);
    rx_shift_upd = rx_shift;
    rx_shift_upd[bit_pos] = sample_high;
  end

  // Event flags reported with this request
  always_comb begin
    word_ready   = bit_event && (phase == PH_RX) && (bit_pos == '0) && (rx_shift_upd != '0);
    send_ok      = bit_event && (phase == PH_TX) && (bit_pos == '0) && !ack_expired &&
                   (bus_sample >= carrier_code);
    send_timeout = bit_event && (phase == PH_TX) && (bit_pos == '0) && ack_expired;
  end

  // Next state
  always_comb begin
    phase_next         = phase;
    bit_pos_next       = bit_pos;
    period_left_next   = period_left;
    rx_shift_next      = rx_shift;
    tx_shift_next      = tx_shift;
    held_word_next     = held_word;
    rx_tally_next      = rx_tally;
    tx_tally_next      = tx_tally;
    drive_level_next   = drive_level;
    carrier_level_next = carrier_level;
    ack_count_next     = ack_count;
    unique case (op)
      OP_EDGE: begin
        // Start reception on a qualified low edge while idle
        if (phase == PH_IDLE && !sample_high) begin
          rx_shift_next    = '0;
          phase_next       = PH_RX;
          bit_pos_next     = POS_BITS'(WORD_BITS - 1);
          period_left_next = bit_period >> 2;
        end
      end
      OP_SEND: begin
        // A send always restarts transmission with the inverted MSB on the line
        tx_shift_next      = send_word;
        phase_next         = PH_TX;
        bit_pos_next       = POS_BITS'(WORD_BITS - 1);
        ack_count_next     = '0;
        carrier_level_next = 1'b1;
        drive_level_next   = !send_word[WORD_BITS-1];
        period_left_next   = bit_period;
      end
      OP_TICK: begin
        if (phase != PH_IDLE) begin
          if (!bit_event) begin
            period_left_next = period_left - PERIOD_BITS'(1);
          end else begin
            period_left_next = bit_period;
            if (phase == PH_RX) begin
              rx_shift_next = rx_shift_upd;
              if (bit_pos == '0) begin
                phase_next = PH_IDLE;
                if (word_ready) begin
                  held_word_next = rx_shift_upd;
                  rx_tally_next  = rx_tally + TALLY_BITS'(1);
                end
              end else begin
                bit_pos_next = bit_pos - POS_BITS'(1);
              end
            end else if (bit_pos != '0) begin
              drive_level_next = !tx_shift[tx_next_pos];
              bit_pos_next     = tx_next_pos;
            end else begin
              // Line released, now watching for the acknowledge voltage
              drive_level_next   = 1'b0;
              carrier_level_next = 1'b0;
              if (send_timeout) begin
                phase_next = PH_IDLE;
              end else begin
                ack_count_next = ack_count + ACK_BITS'(1);
                if (send_ok) begin
                  tx_tally_next = tx_tally + TALLY_BITS'(1);
                  phase_next    = PH_IDLE;
                end
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      bit_pos       <= '0;
      period_left   <= '0;
      rx_shift      <= '0;
      tx_shift      <= '0;
      held_word     <= '0;
      rx_tally      <= '0;
      tx_tally      <= '0;
      drive_level   <= 1'b0;
      carrier_level <= 1'b0;
      ack_count     <= '0;
    end else if (in_take) begin
      phase         <= phase_next;
      bit_pos       <= bit_pos_next;
      period_left   <= period_left_next;
      rx_shift      <= rx_shift_next;
      tx_shift      <= tx_shift_next;
      held_word     <= held_word_next;
      rx_tally      <= rx_tally_next;
      tx_tally      <= tx_tally_next;
      drive_level   <= drive_level_next;
      carrier_level <= carrier_level_next;
      ack_count     <= ack_count_next;
    end
  end

  // Output register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      m_tdata <= {{(OUT_DATA_BITS - OUT_USED_BITS){1'b0}},
                  tx_tally_next, rx_tally_next, send_timeout, send_ok,
                  held_word_next, word_ready, phase_next,
                  carrier_level_next, drive_level_next};
    end
  end

  // The line is only driven under carrier, and the carrier only while sending
  `ASSERT_ALWAYS(a_drive_under_carrier, !drive_level || carrier_level, "line driven without carrier")
  `ASSERT_ALWAYS(a_carrier_in_tx, !carrier_level || phase == PH_TX, "carrier on outside transmit")
  // A qualified edge in idle must start reception
  `ASSERT_NEXT(a_edge_starts_rx, in_take && op == OP_EDGE && phase == PH_IDLE && !sample_high, phase == PH_RX, "qualified edge did not start reception")

endmodule
